// ----- sv/cfmm_pkg.sv -----
`timescale 1ns / 1ps

package cfmm_pkg;

    // default parameter values
    localparam int SOURCE_CHANNELS_DEF = 2;
    localparam int DEST_CHANNELS_DEF   = 2;
    localparam int POSITION_BITS_DEF   = 24;

    // field widths
    localparam int SAMPLE_W    = 24;
    localparam int ACC_W       = 32;
    localparam int MIX_GAIN_W  = 16;
    localparam int CLIP_GAIN_W = 20;
    localparam int LEN_W       = 24;
    localparam int CLIP_LEN_W  = 25;
    localparam int DIV_W       = 25;
    localparam int EDGE_W      = 17;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_IDX_W   = 3;

    // long division of the fade ratios, bits resolved per pipeline stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CLIP_LENGTH     = 3'd0;
    localparam t_cfg_idx CFG_FADE_IN_LENGTH  = 3'd1;
    localparam t_cfg_idx CFG_FADE_OUT_LENGTH = 3'd2;
    localparam t_cfg_idx CFG_CLIP_GAIN       = 3'd3;
    localparam t_cfg_idx CFG_MIX_D0_S0       = 3'd4;
    localparam t_cfg_idx CFG_MIX_D0_S1       = 3'd5;
    localparam t_cfg_idx CFG_MIX_D1_S0       = 3'd6;
    localparam t_cfg_idx CFG_MIX_D1_S1       = 3'd7;

    localparam logic [CLIP_LEN_W-1:0]         CLIP_LENGTH_RST = 25'h100_0000;
    localparam logic signed [CLIP_GAIN_W-1:0] CLIP_GAIN_RST   = 20'sd16384;
    localparam logic signed [MIX_GAIN_W-1:0]  MIX_UNITY_RST   = 16'sd4096;

    localparam logic [EDGE_W-1:0]       UNITY_Q16 = 17'h1_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX   = 32'sh7fff_ffff;
    localparam logic signed [ACC_W-1:0] ACC_MIN   = 32'sh8000_0000;

    // partial remainder and quotient of one fade divider lane
    typedef struct packed {
        logic [LEN_W-1:0]  rem;
        logic [FRAC_W-1:0] quo;
    } t_div_lane;

    // per-item payload carried down the pipe
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic signed [ACC_W-1:0]    acc_a;
        logic signed [ACC_W-1:0]    acc_b;
        logic                       block_end;
        logic                       fin_act;
        logic                       fout_act;
        logic                       fout_zero;
        logic [EDGE_W-1:0]          level;
    } t_item;

    // one restoring division step; remainder stays below the divisor
    function automatic t_div_lane div_step(input t_div_lane x, input logic [DIV_W-1:0] d);
        logic [DIV_W-1:0] r2;
        t_div_lane        y;
        r2 = {x.rem, 1'b0};
        y.quo = {x.quo[FRAC_W-2:0], (r2 >= d)};
        if (r2 >= d) begin
            r2 = r2 - d;
        end
        y.rem = r2[LEN_W-1:0];
        return y;
    endfunction

endpackage

// ----- sv/clip_fade_matrix_mixer_top.sv -----
// A frame passes the entry stage, the divider stages and then the edge, gain,
// mix, part, term and output stages: 15 register stages in all. One frame per
// clock unless the pipe is full and i_ready low; the fade ratios come from a
// pipelined long division, two quotient bits per stage. Empty stages absorb stalls.
// Reset (synchronous, i_rst_n low) empties the pipe and loads the register
// defaults: full-length clip, fades off, unity clip gain, identity matrix.
`timescale 1ns / 1ps

module clip_fade_matrix_mixer_top
    import cfmm_pkg::*;
#(
    parameter int SOURCE_CHANNELS = SOURCE_CHANNELS_DEF,
    parameter int DEST_CHANNELS   = DEST_CHANNELS_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [POSITION_BITS-1:0]      i_position,
    input  logic signed [SAMPLE_W-1:0]    i_sample_a,
    input  logic signed [SAMPLE_W-1:0]    i_sample_b,
    input  logic signed [ACC_W-1:0]       i_acc_in_a,
    input  logic signed [ACC_W-1:0]       i_acc_in_b,
    input  logic                          i_block_end,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ACC_W-1:0]       o_acc_out_a,
    output logic signed [ACC_W-1:0]       o_acc_out_b,
    output logic [EDGE_W-1:0]             o_edge_level,
    output logic                          o_block_done,
    output logic                          o_clipped
);

    localparam int ST_EDGE  = DIV_STAGES + 1;
    localparam int ST_GAIN  = DIV_STAGES + 2;
    localparam int ST_MIX   = DIV_STAGES + 3;
    localparam int ST_PART  = DIV_STAGES + 4;
    localparam int ST_TERM  = DIV_STAGES + 5;
    localparam int ST_OUT   = DIV_STAGES + 6;
    localparam int N_STAGES = DIV_STAGES + 7;
    localparam int CMP_W    = (POSITION_BITS > CLIP_LEN_W) ? POSITION_BITS : CLIP_LEN_W;

    localparam int PROD_W  = 2 * SAMPLE_W - 8;     // sample x matrix gain
    localparam int MIX_W   = PROD_W + 1;
    localparam int LO_W    = 24;
    localparam int PLO_W   = LO_W + 1 + CLIP_GAIN_W;
    localparam int PHI_W   = MIX_W - LO_W + CLIP_GAIN_W;
    localparam int FULL_W  = 62;
    localparam int TERM_W  = FULL_W - 26;
    localparam int SUM_W   = TERM_W + 1;

    // ---------------- configuration ----------------
    logic [CLIP_LEN_W-1:0]         r_clip_len;
    logic [LEN_W-1:0]              r_fi_len;
    logic [LEN_W-1:0]              r_fo_len;
    logic [DIV_W-1:0]              r_fi_div;
    logic [DIV_W-1:0]              r_fo_div;
    logic signed [CLIP_GAIN_W-1:0] r_clip_gain;
    logic signed [MIX_GAIN_W-1:0]  r_mix00;
    logic signed [MIX_GAIN_W-1:0]  r_mix01;
    logic signed [MIX_GAIN_W-1:0]  r_mix10;
    logic signed [MIX_GAIN_W-1:0]  r_mix11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_len  <= CLIP_LENGTH_RST;
            r_fi_len    <= '0;
            r_fo_len    <= '0;
            r_fi_div    <= DIV_W'(1);
            r_fo_div    <= DIV_W'(1);
            r_clip_gain <= CLIP_GAIN_RST;
            r_mix00     <= MIX_UNITY_RST;
            r_mix01     <= '0;
            r_mix10     <= '0;
            r_mix11     <= MIX_UNITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLIP_LENGTH: begin
                    r_clip_len <= i_cfg_data[CLIP_LEN_W-1:0];
                end
                CFG_FADE_IN_LENGTH: begin
                    r_fi_len <= i_cfg_data[LEN_W-1:0];
                    r_fi_div <= {1'b0, i_cfg_data[LEN_W-1:0]} + DIV_W'(1);
                end
                CFG_FADE_OUT_LENGTH: begin
                    r_fo_len <= i_cfg_data[LEN_W-1:0];
                    r_fo_div <= {1'b0, i_cfg_data[LEN_W-1:0]} + DIV_W'(1);
                end
                CFG_CLIP_GAIN: begin
                    r_clip_gain <= i_cfg_data[CLIP_GAIN_W-1:0];
                end
                CFG_MIX_D0_S0: begin
                    r_mix00 <= i_cfg_data[MIX_GAIN_W-1:0];
                end
                CFG_MIX_D0_S1: begin
                    r_mix01 <= i_cfg_data[MIX_GAIN_W-1:0];
                end
                CFG_MIX_D1_S0: begin
                    r_mix10 <= i_cfg_data[MIX_GAIN_W-1:0];
                end
                CFG_MIX_D1_S1: begin
                    r_mix11 <= i_cfg_data[MIX_GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline flow ----------------
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] adv;

    // a stage may load when it or any stage above it is empty, or the sink takes
    always_comb begin
        for (int k = 0; k < N_STAGES; k++) begin
            adv[k] = i_ready || ((r_vld | ((N_STAGES'(1) << k) - N_STAGES'(1))) != '1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[ST_OUT];

    // ---------------- entry: fade window and divider numerators ----------------
    logic [CMP_W-1:0]        pos_x;
    logic signed [CMP_W:0]   rem_x;
    logic                    n_fin_act;
    logic                    n_fout_act;
    logic                    n_fout_zero;
    t_div_lane               n_num_in;
    t_div_lane               n_num_out;
    t_item                   n_item0;
    t_item                   n_item_edge;

    always_comb begin
        pos_x       = CMP_W'(i_position);
        rem_x       = $signed({1'b0, CMP_W'(r_clip_len)}) - $signed({1'b0, pos_x});
        n_fin_act   = (r_fi_len != '0) && (pos_x < CMP_W'(r_fi_len));
        n_fout_act  = (r_fo_len != '0) && (rem_x <= $signed({1'b0, CMP_W'(r_fo_len)}));
        n_fout_zero = rem_x[CMP_W] || (rem_x == '0);

        n_num_in.quo  = '0;
        n_num_in.rem  = n_fin_act ? (pos_x[LEN_W-1:0] + LEN_W'(1)) : '0;
        n_num_out.quo = '0;
        n_num_out.rem = (n_fout_act && !n_fout_zero) ? rem_x[LEN_W-1:0] : '0;

        n_item0.sample_a  = i_sample_a;
        n_item0.sample_b  = (SOURCE_CHANNELS > 1) ? i_sample_b : '0;
        n_item0.acc_a     = i_acc_in_a;
        n_item0.acc_b     = i_acc_in_b;
        n_item0.block_end = i_block_end;
        n_item0.fin_act   = n_fin_act;
        n_item0.fout_act  = n_fout_act;
        n_item0.fout_zero = n_fout_zero;
        n_item0.level     = '0;
    end

    // ---------------- fade dividers ----------------
    t_div_lane r_din  [DIV_STAGES+1];
    t_div_lane r_dout [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_din[0]  <= n_num_in;
            r_dout[0] <= n_num_out;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        t_div_lane n_lane_in;
        t_div_lane n_lane_out;

        always_comb begin
            n_lane_in  = r_din[k-1];
            n_lane_out = r_dout[k-1];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                n_lane_in  = div_step(n_lane_in, r_fi_div);
                n_lane_out = div_step(n_lane_out, r_fo_div);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_din[k]  <= n_lane_in;
                r_dout[k] <= n_lane_out;
            end
        end
    end

    // ---------------- edge gain ----------------
    t_item                 r_item [ST_TERM+1];
    logic [EDGE_W-1:0]     gin;
    logic [EDGE_W-1:0]     gout;
    logic [2*EDGE_W-1:0]   edge_prod;

    always_comb begin
        gin  = r_item[DIV_STAGES].fin_act ? {1'b0, r_din[DIV_STAGES].quo} : UNITY_Q16;
        if (!r_item[DIV_STAGES].fout_act) begin
            gout = UNITY_Q16;
        end else if (r_item[DIV_STAGES].fout_zero) begin
            gout = '0;
        end else begin
            gout = {1'b0, r_dout[DIV_STAGES].quo};
        end
        edge_prod   = gin * gout;
        n_item_edge = r_item[DIV_STAGES];
        n_item_edge.level = edge_prod[FRAC_W+EDGE_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_item[0] <= n_item0;
        end
        for (int k = 1; k <= ST_TERM; k++) begin
            if (adv[k]) begin
                r_item[k] <= (k == ST_EDGE) ? n_item_edge : r_item[k-1];
            end
        end
    end

    // ---------------- gain and matrix products ----------------
    logic signed [CLIP_GAIN_W+EDGE_W:0] g_full;
    logic signed [CLIP_GAIN_W-1:0]      r_g;
    logic signed [PROD_W-1:0]           r_p00;
    logic signed [PROD_W-1:0]           r_p01;
    logic signed [PROD_W-1:0]           r_p10;
    logic signed [PROD_W-1:0]           r_p11;

    assign g_full = r_clip_gain * $signed({1'b0, r_item[ST_EDGE].level});

    always_ff @(posedge i_clk) begin
        if (adv[ST_GAIN]) begin
            r_g   <= g_full[FRAC_W+CLIP_GAIN_W-1:FRAC_W];
            r_p00 <= r_item[ST_EDGE].sample_a * r_mix00;
            r_p01 <= r_item[ST_EDGE].sample_b * r_mix01;
            r_p10 <= r_item[ST_EDGE].sample_a * r_mix10;
            r_p11 <= r_item[ST_EDGE].sample_b * r_mix11;
        end
    end

    // ---------------- matrix sums ----------------
    logic signed [MIX_W-1:0]       r_mix0;
    logic signed [MIX_W-1:0]       r_mix1;
    logic signed [CLIP_GAIN_W-1:0] r_g_mix;

    always_ff @(posedge i_clk) begin
        if (adv[ST_MIX]) begin
            r_mix0  <= MIX_W'(r_p00) + MIX_W'(r_p01);
            r_mix1  <= MIX_W'(r_p10) + MIX_W'(r_p11);
            r_g_mix <= r_g;
        end
    end

    // ---------------- split product: mix x gain ----------------
    logic signed [PLO_W-1:0] r_plo0;
    logic signed [PHI_W-1:0] r_phi0;
    logic signed [PLO_W-1:0] r_plo1;
    logic signed [PHI_W-1:0] r_phi1;

    always_ff @(posedge i_clk) begin
        if (adv[ST_PART]) begin
            r_plo0 <= $signed({1'b0, r_mix0[LO_W-1:0]}) * r_g_mix;
            r_phi0 <= $signed(r_mix0[MIX_W-1:LO_W]) * r_g_mix;
            r_plo1 <= $signed({1'b0, r_mix1[LO_W-1:0]}) * r_g_mix;
            r_phi1 <= $signed(r_mix1[MIX_W-1:LO_W]) * r_g_mix;
        end
    end

    // ---------------- recombine and floor to Q.23 ----------------
    logic signed [FULL_W-1:0] full0;
    logic signed [FULL_W-1:0] full1;
    logic signed [TERM_W-1:0] r_term0;
    logic signed [TERM_W-1:0] r_term1;

    assign full0 = (FULL_W'(r_phi0) <<< LO_W) + FULL_W'(r_plo0);
    assign full1 = (FULL_W'(r_phi1) <<< LO_W) + FULL_W'(r_plo1);

    always_ff @(posedge i_clk) begin
        if (adv[ST_TERM]) begin
            r_term0 <= full0[FULL_W-1:FULL_W-TERM_W];
            r_term1 <= full1[FULL_W-1:FULL_W-TERM_W];
        end
    end

    // ---------------- accumulate and saturate ----------------
    logic signed [SUM_W-1:0] sum0;
    logic signed [SUM_W-1:0] sum1;
    logic                    sat0;
    logic                    sat1;
    logic signed [ACC_W-1:0] n_out_a;
    logic signed [ACC_W-1:0] n_out_b;
    logic                    n_clip_b;

    always_comb begin
        sum0 = SUM_W'(r_item[ST_TERM].acc_a) + SUM_W'(r_term0);
        sum1 = SUM_W'(r_item[ST_TERM].acc_b) + SUM_W'(r_term1);
        // saturated when the bits above bit 31 disagree with the sign
        sat0 = (sum0[SUM_W-1:ACC_W-1] != '0) && (sum0[SUM_W-1:ACC_W-1] != '1);
        sat1 = (sum1[SUM_W-1:ACC_W-1] != '0) && (sum1[SUM_W-1:ACC_W-1] != '1);
        n_out_a = sat0 ? (sum0[SUM_W-1] ? ACC_MIN : ACC_MAX) : sum0[ACC_W-1:0];
        if (DEST_CHANNELS > 1) begin
            n_out_b  = sat1 ? (sum1[SUM_W-1] ? ACC_MIN : ACC_MAX) : sum1[ACC_W-1:0];
            n_clip_b = sat1;
        end else begin
            n_out_b  = r_item[ST_TERM].acc_b;
            n_clip_b = 1'b0;
        end
    end

    logic signed [ACC_W-1:0] r_out_a;
    logic signed [ACC_W-1:0] r_out_b;
    logic [EDGE_W-1:0]       r_out_level;
    logic                    r_out_done;
    logic                    r_out_clip;

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_out_a     <= n_out_a;
            r_out_b     <= n_out_b;
            r_out_level <= r_item[ST_TERM].level;
            r_out_done  <= r_item[ST_TERM].block_end;
            r_out_clip  <= sat0 || n_clip_b;
        end
    end

    assign o_acc_out_a  = r_out_a;
    assign o_acc_out_b  = r_out_b;
    assign o_edge_level = r_out_level;
    assign o_block_done = r_out_done;
    assign o_clipped    = r_out_clip;

    // ---------------- assertions ----------------
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_edge_level <= UNITY_Q16))
        else $error("edge level above unity");

    a_clip_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            ((o_acc_out_a == ACC_MAX) || (o_acc_out_a == ACC_MIN) ||
             (o_acc_out_b == ACC_MAX) || (o_acc_out_b == ACC_MIN)))
        else $error("clipped item without a saturated sum");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_TERM] && !adv[ST_TERM]) |=>
            (r_vld[ST_TERM] && $stable(r_term0) && $stable(r_term1)))
        else $error("stalled item lost or changed before the output stage");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !adv[0]) |=> (r_vld[0] && $stable(r_din[0]) && $stable(r_dout[0])))
        else $error("entry stage overwritten while the pipe is full");

endmodule
